// ----- rtl/bpc_pkg.sv -----
package bpc_pkg;

   localparam int NUM_STAGES = 12;
   localparam int CSR_DATA_W = 24;

   // round(2^48 / 7864320)
   localparam logic signed [26:0] RECIP_P = 27'sd35791394;
   // round(273.15 * 2^19)
   localparam logic signed [28:0] KELVIN_OFFSET_Q19 = 29'sd143209267;

   typedef enum logic [2:0] {
      CSR_TEMP_COEF_PAIR = 3'd0,
      CSR_PRESS_OFFSET   = 3'd1,
      CSR_PRESS_LIN      = 3'd2,
      CSR_TEMP_PRESS_LIN = 3'd3,
      CSR_CROSS_LIN      = 3'd4,
      CSR_PRESS_QUAD     = 3'd5,
      CSR_CROSS_QUAD     = 3'd6,
      CSR_PRESS_CUBIC    = 3'd7
   } bpc_csr_index_type;

   typedef struct packed {
      logic signed [11:0] c0;
      logic signed [11:0] c1;
      logic signed [19:0] c00;
      logic signed [19:0] c10;
      logic signed [15:0] c01;
      logic signed [15:0] c11;
      logic signed [15:0] c20;
      logic signed [15:0] c21;
      logic signed [15:0] c30;
   } bpc_coef_type;

   typedef struct packed {
      logic signed [23:0] raw_pressure;
      logic signed [23:0] raw_temperature;
      logic        [7:0]  sensor_status;
   } bpc_req_type;

   typedef struct packed {
      logic signed [31:0] temperature_kelvin;
      logic signed [31:0] pressure_pascal;
      logic        [7:0]  status_out;
   } bpc_rsp_type;

endpackage

// ----- rtl/bpc_csr_regs.sv -----
module bpc_csr_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  bpc_pkg::bpc_csr_index_type     csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output bpc_pkg::bpc_coef_type          coef
);
   import bpc_pkg::*;

   bpc_coef_type coef_ff;

   assign csr_ready = 1'b1;
   assign coef      = coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TEMP_COEF_PAIR: begin
               coef_ff.c0 <= csr_wdata[23:12];
               coef_ff.c1 <= csr_wdata[11:0];
            end
            CSR_PRESS_OFFSET:   coef_ff.c00 <= csr_wdata[19:0];
            CSR_PRESS_LIN:      coef_ff.c10 <= csr_wdata[19:0];
            CSR_TEMP_PRESS_LIN: coef_ff.c01 <= csr_wdata[15:0];
            CSR_CROSS_LIN:      coef_ff.c11 <= csr_wdata[15:0];
            CSR_PRESS_QUAD:     coef_ff.c20 <= csr_wdata[15:0];
            CSR_CROSS_QUAD:     coef_ff.c21 <= csr_wdata[15:0];
            CSR_PRESS_CUBIC:    coef_ff.c30 <= csr_wdata[15:0];
            default:            coef_ff <= coef_ff;
         endcase
      end
   end

endmodule

// ----- rtl/bpc_pipe_ctrl.sv -----
module bpc_pipe_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bpc_pkg::NUM_STAGES-1:0] load
);
   import bpc_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign valid_in  = (load & {valid_ff[NUM_STAGES-2:0], req_valid}) | (~load & valid_ff);
   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- rtl/bpc_temp_path.sv -----
module bpc_temp_path (
   input  logic                           clock,
   input  logic [bpc_pkg::NUM_STAGES-1:0] load,
   input  bpc_pkg::bpc_coef_type          coef,
   input  logic signed [23:0]             raw_temperature,
   input  logic        [7:0]              sensor_status,
   output logic signed [31:0]             temperature_kelvin,
   output logic        [7:0]              status_out
);
   import bpc_pkg::*;

   logic signed [35:0] ct_ff;
   logic signed [36:0] tsum_ff;
   logic signed [36:0] tsum_in;
   logic signed [36:0] trnd;
   logic signed [31:0] tk_in;
   logic signed [31:0] tk_ff [2:NUM_STAGES-1];
   logic        [7:0]  status_ff [0:NUM_STAGES-1];

   // units of 2^-19 K, then rounded to 2^-10 K; the result cannot leave int32 range
   assign tsum_in = $signed({coef.c0, 18'd0}) + ct_ff + KELVIN_OFFSET_Q19;
   assign trnd    = tsum_ff + 37'sd256;
   assign tk_in   = 32'($signed(trnd[36:9]));

   always_ff @(posedge clock) begin
      if (load[0]) begin
         ct_ff        <= coef.c1 * raw_temperature;
         status_ff[0] <= sensor_status;
      end
      if (load[1]) begin
         tsum_ff <= tsum_in;
      end
      if (load[2]) begin
         tk_ff[2] <= tk_in;
      end
      for (int k = 3; k < NUM_STAGES; k++) begin
         if (load[k]) begin
            tk_ff[k] <= tk_ff[k-1];
         end
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (load[k]) begin
            status_ff[k] <= status_ff[k-1];
         end
      end
   end

   assign temperature_kelvin = tk_ff[NUM_STAGES-1];
   assign status_out         = status_ff[NUM_STAGES-1];

endmodule

// ----- rtl/bpc_press_path.sv -----
module bpc_press_path (
   input  logic                           clock,
   input  logic [bpc_pkg::NUM_STAGES-1:0] load,
   input  bpc_pkg::bpc_coef_type          coef,
   input  logic signed [23:0]             raw_pressure,
   input  logic signed [23:0]             raw_temperature,
   output logic signed [31:0]             pressure_pascal
);
   import bpc_pkg::*;

   // operands carried down the pipe
   logic signed [23:0] traw_ff [0:6];
   logic signed [33:0] psc_ff [1:6];

   logic signed [49:0] pprod_ff;
   logic signed [49:0] pprod_rnd;
   logic signed [49:0] m30_ff;
   logic signed [49:0] m21_ff;
   logic signed [49:0] a_ff;
   logic signed [49:0] d_ff;
   logic signed [58:0] ahi_ff;
   logic signed [59:0] alo_ff;
   logic signed [58:0] dhi_ff;
   logic signed [59:0] dlo_ff;
   logic signed [83:0] asum;
   logic signed [83:0] dsum;
   logic signed [51:0] pa_ff;
   logic signed [51:0] pd_ff;
   logic signed [53:0] b_ff;
   logic signed [51:0] e_ff;
   logic signed [60:0] bhi_ff;
   logic signed [61:0] blo_ff;
   logic signed [49:0] ehi_ff;
   logic signed [50:0] elo_ff;
   logic signed [87:0] bsum;
   logic signed [75:0] esum;
   logic signed [55:0] pb_ff;
   logic signed [56:0] tp_ff;
   logic signed [56:0] tp2_ff;
   logic signed [55:0] c_ff;
   logic signed [56:0] q_ff;
   logic signed [56:0] qrnd;
   logic signed [31:0] pout_in;
   logic signed [31:0] pout_ff;

   assign pprod_rnd = pprod_ff + 50'sd32768;

   // wide Q32 products split in two halves, summed and rounded a stage later
   assign asum = (ahi_ff <<< 25) + alo_ff + 84'sd2147483648;
   assign dsum = (dhi_ff <<< 25) + dlo_ff + 84'sd2147483648;
   assign bsum = (bhi_ff <<< 27) + blo_ff + 88'sd2147483648;
   // Tsc = raw * 2^13, so the Q32 rounding reduces to a 19-bit shift
   assign esum = (ehi_ff <<< 26) + elo_ff + 76'sd262144;

   // the result cannot leave int32 range
   assign qrnd    = q_ff + 57'sd33554432;
   assign pout_in = 32'($signed(qrnd[56:26]));

   always_ff @(posedge clock) begin
      if (load[0]) begin
         pprod_ff   <= raw_pressure * RECIP_P;
         traw_ff[0] <= raw_temperature;
      end
      for (int k = 1; k <= 6; k++) begin
         if (load[k]) begin
            traw_ff[k] <= traw_ff[k-1];
         end
      end
      if (load[1]) begin
         psc_ff[1] <= $signed(pprod_rnd[49:16]);
      end
      for (int k = 2; k <= 6; k++) begin
         if (load[k]) begin
            psc_ff[k] <= psc_ff[k-1];
         end
      end
      if (load[2]) begin
         m30_ff <= psc_ff[1] * coef.c30;
         m21_ff <= psc_ff[1] * coef.c21;
      end
      if (load[3]) begin
         a_ff <= $signed({coef.c20, 32'd0}) + m30_ff;
         d_ff <= $signed({coef.c11, 32'd0}) + m21_ff;
      end
      if (load[4]) begin
         ahi_ff <= psc_ff[3] * $signed(a_ff[49:25]);
         alo_ff <= psc_ff[3] * $signed({1'b0, a_ff[24:0]});
         dhi_ff <= psc_ff[3] * $signed(d_ff[49:25]);
         dlo_ff <= psc_ff[3] * $signed({1'b0, d_ff[24:0]});
      end
      if (load[5]) begin
         pa_ff <= $signed(asum[83:32]);
         pd_ff <= $signed(dsum[83:32]);
      end
      if (load[6]) begin
         b_ff <= pa_ff + $signed({coef.c10, 32'd0});
         e_ff <= pd_ff + $signed({coef.c01, 32'd0});
      end
      if (load[7]) begin
         bhi_ff <= psc_ff[6] * $signed(b_ff[53:27]);
         blo_ff <= psc_ff[6] * $signed({1'b0, b_ff[26:0]});
         ehi_ff <= traw_ff[6] * $signed(e_ff[51:26]);
         elo_ff <= traw_ff[6] * $signed({1'b0, e_ff[25:0]});
      end
      if (load[8]) begin
         pb_ff <= $signed(bsum[87:32]);
         tp_ff <= $signed(esum[75:19]);
      end
      if (load[9]) begin
         c_ff   <= pb_ff + $signed({coef.c00, 32'd0});
         tp2_ff <= tp_ff;
      end
      if (load[10]) begin
         q_ff <= c_ff + tp2_ff;
      end
      if (load[11]) begin
         pout_ff <= pout_in;
      end
   end

   assign pressure_pascal = pout_ff;

endmodule

// ----- rtl/baro_pressure_compensation.sv -----
// Port group   Handshake              Payload
// req_*        req_valid / req_stall  bpc_req_type: raw pressure, raw temperature, status
// rsp_*        rsp_valid / rsp_stall  bpc_rsp_type: temperature, pressure, status
// csr_*        csr_valid / csr_ready  csr_index, csr_wdata (24 bits)
//
// Twelve register stages, one transfer per cycle while rsp_stall is low; the depth is
// set by the reciprocal multiply and the chain of three Q32 multiplies, the two wide
// ones split in halves.
// Synchronous reset clears the stage valid bits and all coefficients.
// A stall on rsp_* holds the output stage; earlier stages keep filling empty slots,
// and req_stall rises only once every stage holds a transfer.
module baro_pressure_compensation (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bpc_pkg::bpc_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bpc_pkg::bpc_rsp_type           rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  bpc_pkg::bpc_csr_index_type     csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bpc_pkg::*;

   bpc_coef_type          coef;
   logic [NUM_STAGES-1:0] load;
   logic signed [31:0]    temperature_kelvin;
   logic signed [31:0]    pressure_pascal;
   logic        [7:0]     status_out;

   bpc_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   bpc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .load      (load)
   );

   bpc_temp_path u_temp (
      .clock              (clock),
      .load               (load),
      .coef               (coef),
      .raw_temperature    (req_data.raw_temperature),
      .sensor_status      (req_data.sensor_status),
      .temperature_kelvin (temperature_kelvin),
      .status_out         (status_out)
   );

   bpc_press_path u_press (
      .clock           (clock),
      .load            (load),
      .coef            (coef),
      .raw_pressure    (req_data.raw_pressure),
      .raw_temperature (req_data.raw_temperature),
      .pressure_pascal (pressure_pascal)
   );

   assign rsp_data.temperature_kelvin = temperature_kelvin;
   assign rsp_data.pressure_pascal    = pressure_pascal;
   assign rsp_data.status_out         = status_out;

endmodule

// ----- verif/tb_baro_pressure_compensation.sv -----
module tb_baro_pressure_compensation;
   timeunit 1ns;
   timeprecision 1ps;

   import bpc_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int BATCH_ITEMS = 160;
   // 273.15 K in 1/1024 K with every coefficient at zero
   localparam logic signed [31:0] KELVIN_AT_ZERO_COEFS = 32'sd279706;

   typedef struct {
      bit                is_csr;
      bpc_csr_index_type csr_idx;
      logic [23:0]       csr_data;
      bpc_req_type       sample;
      bit                has_fixed;
      bpc_rsp_type       fixed;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   bpc_req_type       req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   bpc_rsp_type       rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   bpc_csr_index_type csr_index = CSR_TEMP_COEF_PAIR;
   logic [23:0]       csr_wdata = '0;

   bpc_coef_type coef_shadow = '0;
   bpc_rsp_type  expected_readings[$];
   bpc_rsp_type  oldest_reading;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           sender_idle_pct = 6;
   int           receiver_stall_pct = 62;
   int           hold_off_requests = 0;
   int           hold_off_served = 0;
   int           hold_off_left = 0;

   baro_pressure_compensation uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // exact Q32 x Q32 product, rounded half up back to Q32
   function automatic longint q32_product(longint x, longint y);
      logic signed [127:0] wx;
      logic signed [127:0] wy;
      logic signed [127:0] wide;
      wx = x;
      wy = y;
      wide = wx * wy + (128'sd1 <<< 31);
      return longint'(wide >>> 32);
   endfunction

   function automatic logic signed [31:0] clamp32(longint x);
      if (x > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (x < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   function automatic bpc_rsp_type compensate_sample(bpc_req_type s);
      bpc_rsp_type r;
      longint praw, traw, c0, c1, c00, c10, c01, c11, c20, c21, c30;
      longint tsum, psc, tsc, a, b, c, d, e, q;
      praw = longint'($signed(s.raw_pressure));
      traw = longint'($signed(s.raw_temperature));
      c0   = longint'($signed(coef_shadow.c0));
      c1   = longint'($signed(coef_shadow.c1));
      c00  = longint'($signed(coef_shadow.c00));
      c10  = longint'($signed(coef_shadow.c10));
      c01  = longint'($signed(coef_shadow.c01));
      c11  = longint'($signed(coef_shadow.c11));
      c20  = longint'($signed(coef_shadow.c20));
      c21  = longint'($signed(coef_shadow.c21));
      c30  = longint'($signed(coef_shadow.c30));

      tsum = c0 * 262144 + c1 * traw + longint'(KELVIN_OFFSET_Q19);
      r.temperature_kelvin = clamp32((tsum + 256) >>> 9);

      psc = (praw * longint'(RECIP_P) + 32768) >>> 16;
      tsc = traw <<< 13;
      a = (c20 <<< 32) + q32_product(psc, c30 <<< 32);
      b = (c10 <<< 32) + q32_product(psc, a);
      c = (c00 <<< 32) + q32_product(psc, b);
      d = (c11 <<< 32) + q32_product(psc, c21 <<< 32);
      e = (c01 <<< 32) + q32_product(psc, d);
      q = c + q32_product(tsc, e);
      r.pressure_pascal = clamp32((q + (longint'(1) <<< 25)) >>> 26);
      r.status_out = s.sensor_status;
      return r;
   endfunction

   task automatic report_mismatch(string field, longint exp_val, longint got_val);
      mismatch_count++;
      $error("%s: expected %0d, got %0d", field, exp_val, got_val);
   endtask

   // result check and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            mismatch_count++;
            $error("result transfer with no reading outstanding");
         end else begin
            oldest_reading = expected_readings.pop_front();
            if (rsp_data.temperature_kelvin !== oldest_reading.temperature_kelvin)
               report_mismatch("temperature_kelvin",
                               longint'($signed(oldest_reading.temperature_kelvin)),
                               longint'($signed(rsp_data.temperature_kelvin)));
            if (rsp_data.pressure_pascal !== oldest_reading.pressure_pascal)
               report_mismatch("pressure_pascal",
                               longint'($signed(oldest_reading.pressure_pascal)),
                               longint'($signed(rsp_data.pressure_pascal)));
            if (rsp_data.status_out !== oldest_reading.status_out)
               report_mismatch("status_out", longint'(oldest_reading.status_out),
                               longint'(rsp_data.status_out));
         end
      end
      if (hold_off_left != 0) begin
         rsp_stall <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_served != hold_off_requests) begin
         rsp_stall <= 1'b1;
         hold_off_served <= hold_off_served + 1;
         hold_off_left <= HOLD_OFF_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   task automatic send_sample(bpc_req_type s, bit has_fixed, bpc_rsp_type fixed);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (req_stall);
      if (has_fixed)
         expected_readings.push_back(fixed);
      else
         expected_readings.push_back(compensate_sample(s));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 2) @(posedge clock);
   endtask

   task automatic csr_write(bpc_csr_index_type idx, logic [23:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TEMP_COEF_PAIR: begin
            coef_shadow.c0 = d[23:12];
            coef_shadow.c1 = d[11:0];
         end
         CSR_PRESS_OFFSET:   coef_shadow.c00 = d[19:0];
         CSR_PRESS_LIN:      coef_shadow.c10 = d[19:0];
         CSR_TEMP_PRESS_LIN: coef_shadow.c01 = d[15:0];
         CSR_CROSS_LIN:      coef_shadow.c11 = d[15:0];
         CSR_PRESS_QUAD:     coef_shadow.c20 = d[15:0];
         CSR_CROSS_QUAD:     coef_shadow.c21 = d[15:0];
         CSR_PRESS_CUBIC:    coef_shadow.c30 = d[15:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [23:0] coef_value(int w, bit corners);
      if (!corners) return 24'($urandom());
      case ($urandom_range(0, 4))
         0: return (24'h1 << (w - 1)) - 24'h1;
         1: return 24'h1 << (w - 1);
         2: return '0;
         3: return '1;
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic program_coefficients(bit corners);
      bpc_csr_index_type idx;
      logic [23:0] hi_half, lo_half, v, fill, field_mask;
      int w;
      idx = CSR_TEMP_COEF_PAIR;
      do begin
         if (idx == CSR_TEMP_COEF_PAIR) begin
            hi_half = coef_value(12, corners);
            lo_half = coef_value(12, corners);
            csr_write(idx, {hi_half[11:0], lo_half[11:0]});
         end else begin
            w = (idx == CSR_PRESS_OFFSET || idx == CSR_PRESS_LIN) ? 20 : 16;
            field_mask = (24'h1 << w) - 24'h1;
            v = coef_value(w, corners);
            fill = 24'($urandom());
            csr_write(idx, (fill & ~field_mask) | (v & field_mask));
         end
         idx = idx.next();
      end while (idx != CSR_TEMP_COEF_PAIR);
   endtask

   function automatic logic [23:0] raw_value();
      case ($urandom_range(0, 15))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return '0;
         3: return '1;
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic stim_row_type csr_row(bpc_csr_index_type idx, logic [23:0] d);
      stim_row_type r;
      r = '{csr_idx: CSR_TEMP_COEF_PAIR, default: '0};
      r.is_csr = 1'b1;
      r.csr_idx = idx;
      r.csr_data = d;
      return r;
   endfunction

   function automatic stim_row_type sample_row(logic [23:0] p, logic [23:0] t, logic [7:0] st,
                                               bit has_fixed, logic [31:0] kelvin,
                                               logic [31:0] pascal);
      stim_row_type r;
      r = '{csr_idx: CSR_TEMP_COEF_PAIR, default: '0};
      r.sample.raw_pressure = p;
      r.sample.raw_temperature = t;
      r.sample.sensor_status = st;
      r.has_fixed = has_fixed;
      r.fixed.temperature_kelvin = kelvin;
      r.fixed.pressure_pascal = pascal;
      r.fixed.status_out = st;
      return r;
   endfunction

   initial begin
      stim_row_type rows[$];
      bpc_req_type  s;

      // reset coefficients: pressure 0, temperature 273.15 K
      rows.push_back(sample_row(24'h000000, 24'h000000, 8'h00, 1, KELVIN_AT_ZERO_COEFS, 0));
      rows.push_back(sample_row(24'h7FFFFF, 24'h7FFFFF, 8'hFF, 1, KELVIN_AT_ZERO_COEFS, 0));
      rows.push_back(sample_row(24'h800000, 24'h800000, 8'h00, 1, KELVIN_AT_ZERO_COEFS, 0));
      rows.push_back(sample_row(24'h7FFFFF, 24'h800000, 8'hA5, 1, KELVIN_AT_ZERO_COEFS, 0));
      rows.push_back(sample_row(24'h800000, 24'h7FFFFF, 8'h5A, 1, KELVIN_AT_ZERO_COEFS, 0));
      rows.push_back(sample_row(24'hFFFFFF, 24'hFFFFFF, 8'h01, 1, KELVIN_AT_ZERO_COEFS, 0));

      // all coefficients at positive full scale, junk above each 20- and 16-bit field
      rows.push_back(csr_row(CSR_TEMP_COEF_PAIR, 24'h7FF7FF));
      rows.push_back(csr_row(CSR_PRESS_OFFSET,   24'hF7FFFF));
      rows.push_back(csr_row(CSR_PRESS_LIN,      24'hF7FFFF));
      rows.push_back(csr_row(CSR_TEMP_PRESS_LIN, 24'hFF7FFF));
      rows.push_back(csr_row(CSR_CROSS_LIN,      24'hFF7FFF));
      rows.push_back(csr_row(CSR_PRESS_QUAD,     24'hFF7FFF));
      rows.push_back(csr_row(CSR_CROSS_QUAD,     24'hFF7FFF));
      rows.push_back(csr_row(CSR_PRESS_CUBIC,    24'hFF7FFF));
      rows.push_back(sample_row(24'h7FFFFF, 24'h7FFFFF, 8'h80, 0, 0, 0));
      rows.push_back(sample_row(24'h800000, 24'h800000, 8'h7F, 0, 0, 0));
      rows.push_back(sample_row(24'h7FFFFF, 24'h800000, 8'h33, 0, 0, 0));
      rows.push_back(sample_row(24'h800000, 24'h7FFFFF, 8'hCC, 0, 0, 0));

      // all coefficients at negative full scale
      rows.push_back(csr_row(CSR_TEMP_COEF_PAIR, 24'h800800));
      rows.push_back(csr_row(CSR_PRESS_OFFSET,   24'h580000));
      rows.push_back(csr_row(CSR_PRESS_LIN,      24'h580000));
      rows.push_back(csr_row(CSR_TEMP_PRESS_LIN, 24'h5A8000));
      rows.push_back(csr_row(CSR_CROSS_LIN,      24'h5A8000));
      rows.push_back(csr_row(CSR_PRESS_QUAD,     24'h5A8000));
      rows.push_back(csr_row(CSR_CROSS_QUAD,     24'h5A8000));
      rows.push_back(csr_row(CSR_PRESS_CUBIC,    24'h5A8000));
      rows.push_back(sample_row(24'h7FFFFF, 24'h7FFFFF, 8'hF0, 0, 0, 0));
      rows.push_back(sample_row(24'h800000, 24'h800000, 8'h0F, 0, 0, 0));
      rows.push_back(sample_row(24'h7FFFFF, 24'h800000, 8'h69, 0, 0, 0));
      rows.push_back(sample_row(24'h800000, 24'h7FFFFF, 8'h96, 0, 0, 0));

      // mixed signs
      rows.push_back(csr_row(CSR_TEMP_COEF_PAIR, 24'h8007FF));
      rows.push_back(csr_row(CSR_PRESS_OFFSET,   24'h07FFFF));
      rows.push_back(csr_row(CSR_PRESS_LIN,      24'h080000));
      rows.push_back(csr_row(CSR_TEMP_PRESS_LIN, 24'h007FFF));
      rows.push_back(csr_row(CSR_CROSS_LIN,      24'h008000));
      rows.push_back(csr_row(CSR_PRESS_QUAD,     24'h007FFF));
      rows.push_back(csr_row(CSR_CROSS_QUAD,     24'h008000));
      rows.push_back(csr_row(CSR_PRESS_CUBIC,    24'h00FFFF));
      rows.push_back(sample_row(24'h7FFFFF, 24'h800000, 8'h11, 0, 0, 0));
      rows.push_back(sample_row(24'hFFFFFF, 24'h000001, 8'h22, 0, 0, 0));
      rows.push_back(sample_row(24'h000000, 24'h7FFFFF, 8'h44, 0, 0, 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            wait_idle();
            csr_write(rows[i].csr_idx, rows[i].csr_data);
         end else begin
            send_sample(rows[i].sample, rows[i].has_fixed, rows[i].fixed);
         end
      end

      for (int mode = 0; mode < 3; mode++) begin
         for (int setting = 0; setting < 4; setting++) begin
            wait_idle();
            case (mode)
               0: begin
                  sender_idle_pct = 6;
                  receiver_stall_pct = 62;
               end
               1: begin
                  sender_idle_pct = 62;
                  receiver_stall_pct = 6;
               end
               default: begin
                  sender_idle_pct = 0;
                  receiver_stall_pct = 0;
               end
            endcase
            program_coefficients(setting % 2 == 1);
            // long receiver hold-off while samples keep coming
            if (setting == 0) hold_off_requests++;
            repeat (BATCH_ITEMS) begin
               s.raw_pressure = raw_value();
               s.raw_temperature = raw_value();
               s.sensor_status = 8'($urandom());
               send_sample(s, 1'b0, '0);
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
